/* rtl/bawf_pkg.sv */
package bawf_pkg;

    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int COEF_FRAC_BITS_DEF  = 14;

    localparam int FIELD_W  = 16;
    localparam int COEF_W   = 17;
    localparam int OFS_W    = 18;
    localparam int FRAME_W  = 13;
    localparam int CORNER_W = 19;
    localparam int PROD_W   = COEF_W + CORNER_W;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_INDEX_W = 4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_COEF_XX      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_XY      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_YX      = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_YY      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y     = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] class_id;
        logic [FIELD_W-1:0] center_x;
        logic [FIELD_W-1:0] center_y;
        logic [FIELD_W-1:0] box_width;
        logic [FIELD_W-1:0] box_height;
    } box_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] out_class;
        logic [FIELD_W-1:0] out_center_x;
        logic [FIELD_W-1:0] out_center_y;
        logic [FIELD_W-1:0] out_width;
        logic [FIELD_W-1:0] out_height;
    } box_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [OFS_W-1:0]  offset_x;
        logic signed [COEF_W-1:0] coef_yx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [OFS_W-1:0]  offset_y;
        logic [FRAME_W-1:0]       frame_width;
        logic [FRAME_W-1:0]       frame_height;
    } cfg_t;

    // mapped corner terms; x hull is min/max over (pxx*) plus min/max over (pxy*)
    typedef struct packed {
        logic [FIELD_W-1:0]       class_id;
        logic [FIELD_W-1:0]       box_width;
        logic [FIELD_W-1:0]       box_height;
        logic signed [PROD_W-1:0] pxx0;
        logic signed [PROD_W-1:0] pxx1;
        logic signed [PROD_W-1:0] pxy0;
        logic signed [PROD_W-1:0] pxy1;
        logic signed [PROD_W-1:0] pyx0;
        logic signed [PROD_W-1:0] pyx1;
        logic signed [PROD_W-1:0] pyy0;
        logic signed [PROD_W-1:0] pyy1;
    } terms_t;

endpackage

/* rtl/bawf_front.sv */
module bawf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  bawf_pkg::box_in_t      in_data,
    input  bawf_pkg::cfg_t         cfg,
    input  logic [bawf_pkg::QCNT_W-1:0] q_count,
    output logic                   push,
    output bawf_pkg::terms_t       push_data
);
    import bawf_pkg::*;

    logic                       v1_reg;
    logic [FIELD_W-1:0]         cls1_reg, w1_reg, h1_reg;
    logic signed [CORNER_W-1:0] xs0_reg, xs1_reg, ys0_reg, ys1_reg;
    logic                       v2_reg;
    terms_t                     t2_reg;
    logic                       accept;
    logic [QCNT_W+1:0]          inflight;

    assign inflight = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(v1_reg) + (QCNT_W+2)'(v2_reg);
    assign in_stall = inflight >= (QCNT_W+2)'(QDEPTH);
    assign accept   = in_valid && !in_stall;
    assign push      = v2_reg;
    assign push_data = t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cls1_reg <= in_data.class_id;
        w1_reg   <= in_data.box_width;
        h1_reg   <= in_data.box_height;
        xs0_reg  <= $signed({2'b00, in_data.center_x, 1'b0}) - $signed({3'b000, in_data.box_width});
        xs1_reg  <= $signed({2'b00, in_data.center_x, 1'b0}) + $signed({3'b000, in_data.box_width});
        ys0_reg  <= $signed({2'b00, in_data.center_y, 1'b0}) - $signed({3'b000, in_data.box_height});
        ys1_reg  <= $signed({2'b00, in_data.center_y, 1'b0}) + $signed({3'b000, in_data.box_height});

        t2_reg.class_id   <= cls1_reg;
        t2_reg.box_width  <= w1_reg;
        t2_reg.box_height <= h1_reg;
        t2_reg.pxx0 <= PROD_W'(cfg.coef_xx) * PROD_W'(xs0_reg);
        t2_reg.pxx1 <= PROD_W'(cfg.coef_xx) * PROD_W'(xs1_reg);
        t2_reg.pxy0 <= PROD_W'(cfg.coef_xy) * PROD_W'(ys0_reg);
        t2_reg.pxy1 <= PROD_W'(cfg.coef_xy) * PROD_W'(ys1_reg);
        t2_reg.pyx0 <= PROD_W'(cfg.coef_yx) * PROD_W'(xs0_reg);
        t2_reg.pyx1 <= PROD_W'(cfg.coef_yx) * PROD_W'(xs1_reg);
        t2_reg.pyy0 <= PROD_W'(cfg.coef_yy) * PROD_W'(ys0_reg);
        t2_reg.pyy1 <= PROD_W'(cfg.coef_yy) * PROD_W'(ys1_reg);
    end

endmodule

/* rtl/bawf_queue.sv */
module bawf_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  bawf_pkg::terms_t            din,
    input  logic                        pop,
    output bawf_pkg::terms_t            dout,
    output logic [bawf_pkg::QCNT_W-1:0] count
);
    import bawf_pkg::*;

    terms_t              mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign count = count_reg;
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= din;
    end

endmodule

/* rtl/bawf_back.sv */
module bawf_back #(
    parameter int COORD_FRAC_BITS = bawf_pkg::COORD_FRAC_BITS_DEF,
    parameter int COEF_FRAC_BITS  = bawf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  bawf_pkg::terms_t       q_data,
    output logic                   pop,
    input  bawf_pkg::cfg_t         cfg,
    output logic                   out_valid,
    input  logic                   out_stall,
    output bawf_pkg::box_out_t     out_data
);
    import bawf_pkg::*;

    localparam int SH     = COEF_FRAC_BITS + 1;
    localparam int FBITS  = COORD_FRAC_BITS + COEF_FRAC_BITS + 1;
    localparam int OX_W   = OFS_W + SH;
    localparam int SUM_W  = ((PROD_W + 1 > OX_W) ? PROD_W + 1 : OX_W) + 1;
    localparam int LIM_W  = FRAME_W + FBITS;
    localparam int CL_W   = (SUM_W > LIM_W + 1) ? SUM_W : LIM_W + 1;
    localparam int Q_W    = FRAME_W + COORD_FRAC_BITS;
    localparam int SAT_W  = (Q_W + 1 > FIELD_W + 1) ? Q_W + 1 : FIELD_W + 1;
    localparam int AREA_W = 2 * Q_W;
    localparam int CMP_W  = (AREA_W + 4 > 2 * FIELD_W) ? AREA_W + 4 : 2 * FIELD_W;

    logic en;

    // stage C: hull selection
    logic                     vc_reg;
    logic [FIELD_W-1:0]       clsc_reg, wc_reg, hc_reg;
    logic signed [PROD_W-1:0] mnxa_reg, mnxb_reg, mxxa_reg, mxxb_reg;
    logic signed [PROD_W-1:0] mnya_reg, mnyb_reg, mxya_reg, mxyb_reg;
    // stage D: hull edges
    logic                     vd_reg;
    logic [FIELD_W-1:0]       clsd_reg, wd_reg, hd_reg;
    logic signed [SUM_W-1:0]  minx_reg, maxx_reg, miny_reg, maxy_reg;
    // stage E: clipped, quantized edges
    logic                     ve_reg;
    logic [FIELD_W-1:0]       clse_reg, we_reg, he_reg;
    logic [Q_W-1:0]           qx1_reg, qx2_reg, qy1_reg, qy2_reg;
    // stage F: sizes, centers, areas
    logic                     vf_reg;
    logic [FIELD_W-1:0]       clsf_reg;
    logic                     side_ok_reg;
    logic [AREA_W-1:0]        area_reg;
    logic [2*FIELD_W-1:0]     orig_area_reg;
    logic [FIELD_W-1:0]       ocx_reg, ocy_reg, ow_reg, oh_reg;
    // output register
    logic                     out_valid_reg;
    box_out_t                 out_data_reg;

    logic signed [SUM_W-1:0]  ox_ext, oy_ext;
    logic [Q_W-1:0]           qx1_next, qx2_next, qy1_next, qy2_next;
    logic [Q_W-1:0]           nw, nh;
    logic [SAT_W-1:0]         cx_half, cy_half, nw_ext, nh_ext;
    logic [CMP_W-1:0]         area_ten;
    logic                     keep;

    assign en        = !out_valid_reg || !out_stall;
    assign pop       = en && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign ox_ext = SUM_W'(cfg.offset_x) <<< SH;
    assign oy_ext = SUM_W'(cfg.offset_y) <<< SH;

    function automatic logic [Q_W-1:0] clip_q(input logic signed [SUM_W-1:0] v,
                                             input logic [FRAME_W-1:0] frame);
        logic signed [CL_W-1:0] vx;
        logic [CL_W-1:0]        lim;
        logic [CL_W-1:0]        c;
        vx  = CL_W'(v);
        lim = CL_W'(frame) << FBITS;
        if (vx < 0)
            c = '0;
        else if (vx > $signed(lim))
            c = lim;
        else
            c = vx;
        return Q_W'(c >> SH);
    endfunction

    assign qx1_next = clip_q(minx_reg, cfg.frame_width);
    assign qx2_next = clip_q(maxx_reg, cfg.frame_width);
    assign qy1_next = clip_q(miny_reg, cfg.frame_height);
    assign qy2_next = clip_q(maxy_reg, cfg.frame_height);

    assign nw      = qx2_reg - qx1_reg;
    assign nh      = qy2_reg - qy1_reg;
    assign cx_half = SAT_W'(((Q_W+1)'(qx1_reg) + (Q_W+1)'(qx2_reg)) >> 1);
    assign cy_half = SAT_W'(((Q_W+1)'(qy1_reg) + (Q_W+1)'(qy2_reg)) >> 1);
    assign nw_ext  = SAT_W'(nw);
    assign nh_ext  = SAT_W'(nh);

    assign area_ten = (CMP_W'(area_reg) << 3) + (CMP_W'(area_reg) << 1);
    assign keep = side_ok_reg &&
                  !((orig_area_reg != '0) && (area_ten < CMP_W'(orig_area_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            vf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg        <= q_valid;
            vd_reg        <= vc_reg;
            ve_reg        <= vd_reg;
            vf_reg        <= ve_reg;
            out_valid_reg <= vf_reg && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clsc_reg <= q_data.class_id;
            wc_reg   <= q_data.box_width;
            hc_reg   <= q_data.box_height;
            mnxa_reg <= (q_data.pxx0 < q_data.pxx1) ? q_data.pxx0 : q_data.pxx1;
            mxxa_reg <= (q_data.pxx0 < q_data.pxx1) ? q_data.pxx1 : q_data.pxx0;
            mnxb_reg <= (q_data.pxy0 < q_data.pxy1) ? q_data.pxy0 : q_data.pxy1;
            mxxb_reg <= (q_data.pxy0 < q_data.pxy1) ? q_data.pxy1 : q_data.pxy0;
            mnya_reg <= (q_data.pyx0 < q_data.pyx1) ? q_data.pyx0 : q_data.pyx1;
            mxya_reg <= (q_data.pyx0 < q_data.pyx1) ? q_data.pyx1 : q_data.pyx0;
            mnyb_reg <= (q_data.pyy0 < q_data.pyy1) ? q_data.pyy0 : q_data.pyy1;
            mxyb_reg <= (q_data.pyy0 < q_data.pyy1) ? q_data.pyy1 : q_data.pyy0;

            clsd_reg <= clsc_reg;
            wd_reg   <= wc_reg;
            hd_reg   <= hc_reg;
            minx_reg <= SUM_W'(mnxa_reg) + SUM_W'(mnxb_reg) + ox_ext;
            maxx_reg <= SUM_W'(mxxa_reg) + SUM_W'(mxxb_reg) + ox_ext;
            miny_reg <= SUM_W'(mnya_reg) + SUM_W'(mnyb_reg) + oy_ext;
            maxy_reg <= SUM_W'(mxya_reg) + SUM_W'(mxyb_reg) + oy_ext;

            clse_reg <= clsd_reg;
            we_reg   <= wd_reg;
            he_reg   <= hd_reg;
            qx1_reg  <= qx1_next;
            qx2_reg  <= qx2_next;
            qy1_reg  <= qy1_next;
            qy2_reg  <= qy2_next;

            clsf_reg      <= clse_reg;
            side_ok_reg   <= (nw >= (Q_W'(2) << COORD_FRAC_BITS)) &&
                             (nh >= (Q_W'(2) << COORD_FRAC_BITS));
            area_reg      <= AREA_W'(nw) * AREA_W'(nh);
            orig_area_reg <= (2*FIELD_W)'(we_reg) * (2*FIELD_W)'(he_reg);
            ocx_reg <= (cx_half > SAT_W'(16'hFFFF)) ? 16'hFFFF : cx_half[FIELD_W-1:0];
            ocy_reg <= (cy_half > SAT_W'(16'hFFFF)) ? 16'hFFFF : cy_half[FIELD_W-1:0];
            ow_reg  <= (nw_ext > SAT_W'(16'hFFFF)) ? 16'hFFFF : nw_ext[FIELD_W-1:0];
            oh_reg  <= (nh_ext > SAT_W'(16'hFFFF)) ? 16'hFFFF : nh_ext[FIELD_W-1:0];

            out_data_reg.out_class    <= clsf_reg;
            out_data_reg.out_center_x <= ocx_reg;
            out_data_reg.out_center_y <= ocy_reg;
            out_data_reg.out_width    <= ow_reg;
            out_data_reg.out_height   <= oh_reg;
        end
    end

endmodule

/* rtl/bbox_affine_warp_filter_top.sv */
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------
// input    | in_valid  | in_stall  | in_data  (box_in_t)
// output   | out_valid | out_stall | out_data (box_out_t)
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// One box per cycle sustained while out_stall is low; a box passes the front
// stages, the 4-entry queue between front and back, then back stages C to F.
// Reset (rst_n, async) empties the pipeline and loads the identity matrix
// and a 640x640 frame. An output stall with out_valid high freezes the back
// end; the front keeps accepting until the queue and its own two stages hold 4 boxes.
module bbox_affine_warp_filter_top #(
    parameter int COORD_FRAC_BITS = bawf_pkg::COORD_FRAC_BITS_DEF,
    parameter int COEF_FRAC_BITS  = bawf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  bawf_pkg::box_in_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output bawf_pkg::box_out_t               out_data,
    input  logic                             cfg_we,
    input  logic [bawf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bawf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bawf_pkg::*;

    cfg_t              cfg_reg;
    logic              push, pop;
    terms_t            push_data, q_data;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_xx      <= COEF_W'(1) <<< COEF_FRAC_BITS;
            cfg_reg.coef_xy      <= '0;
            cfg_reg.offset_x     <= '0;
            cfg_reg.coef_yx      <= '0;
            cfg_reg.coef_yy      <= COEF_W'(1) <<< COEF_FRAC_BITS;
            cfg_reg.offset_y     <= '0;
            cfg_reg.frame_width  <= FRAME_W'(640);
            cfg_reg.frame_height <= FRAME_W'(640);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_XX:      cfg_reg.coef_xx      <= cfg_data[COEF_W-1:0];
                REG_COEF_XY:      cfg_reg.coef_xy      <= cfg_data[COEF_W-1:0];
                REG_OFFSET_X:     cfg_reg.offset_x     <= cfg_data[OFS_W-1:0];
                REG_COEF_YX:      cfg_reg.coef_yx      <= cfg_data[COEF_W-1:0];
                REG_COEF_YY:      cfg_reg.coef_yy      <= cfg_data[COEF_W-1:0];
                REG_OFFSET_Y:     cfg_reg.offset_y     <= cfg_data[OFS_W-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[FRAME_W-1:0];
                default:          ;
            endcase
        end
    end

    bawf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    bawf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_data),
        .pop   (pop),
        .dout  (q_data),
        .count (q_count)
    );

    bawf_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_count != '0),
        .q_data    (q_data),
        .pop       (pop),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
